>>> src/ssq_pkg.sv
// shared types and constants for the stable sorted priority queue
// no dependencies; used by the interfaces, the cell and the top level
`default_nettype none

package ssq_pkg;

  localparam int CAPACITY = 16;
  localparam int COUNT_W  = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 31;
  localparam int TYPE_W   = 8;
  localparam int FILL_W   = 5;

  localparam logic ACTION_PUSH = 1'b0;
  localparam logic ACTION_POP  = 1'b1;

  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key;
    logic [KEY_W-1:0]  trans;
    logic [TYPE_W-1:0] etype;
  } entry_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_ADVANCE
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [KEY_W-1:0] key;
  } cell_ctrl_t;

endpackage

`default_nettype wire

>>> src/ssq_if.sv
// valid/ready channel interfaces for request and response words
// depends on ssq_pkg for field widths
`default_nettype none

interface ssq_req_if;
  logic                      valid;
  logic                      ready;
  logic                      action;
  logic [ssq_pkg::KEY_W-1:0] key_time;
  logic [ssq_pkg::KEY_W-1:0] transaction_time;
  logic [ssq_pkg::TYPE_W-1:0] event_type;

  modport source (output valid, action, key_time, transaction_time, event_type,
                  input ready);
  modport sink (input valid, action, key_time, transaction_time, event_type,
                output ready);
endinterface

interface ssq_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       ok;
  logic                       empty_res;
  logic [ssq_pkg::KEY_W-1:0]  head_key;
  logic [ssq_pkg::KEY_W-1:0]  head_transaction;
  logic [ssq_pkg::TYPE_W-1:0] head_type;
  logic [ssq_pkg::FILL_W-1:0] fill_count;

  modport source (output valid, ok, empty_res, head_key, head_transaction, head_type,
                  fill_count, input ready);
  modport sink (input valid, ok, empty_res, head_key, head_transaction, head_type,
                fill_count, output ready);
endinterface

`default_nettype wire

>>> src/ssq_cell.sv
// one slot of the sorted queue: holds an entry, compares it with the pushed key
// and takes the new entry or a neighbor's entry; depends on ssq_pkg
`default_nettype none

module ssq_cell (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ssq_pkg::cell_ctrl_t ctrl,
  input  wire ssq_pkg::entry_t    new_entry,
  input  wire ssq_pkg::entry_t    left,
  input  wire logic               left_keep,
  input  wire ssq_pkg::entry_t    right,
  output ssq_pkg::entry_t         cur,
  output logic                    keep
);

  ssq_pkg::entry_t cur_next;

  assign keep = cur.valid && (cur.key <= ctrl.key);

  always_comb begin
    cur_next = cur;
    case (ctrl.op)
      ssq_pkg::OP_INSERT: begin
        if (!keep) begin
          if (left_keep) begin
            cur_next = new_entry;
          end else begin
            cur_next = left;
          end
        end
      end
      ssq_pkg::OP_ADVANCE: begin
        cur_next = right;
      end
      default: begin
        cur_next = cur;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.valid <= 1'b0;
    end else begin
      cur <= cur_next;
    end
  end

endmodule

`default_nettype wire

>>> src/stable_sorted_priority_queue.sv
// top level: row of sorted slot cells, fill counter and registered response
// depends on ssq_pkg, ssq_if (ssq_req_if, ssq_rsp_if) and ssq_cell
`default_nettype none

// Event queue kept in ascending key order in ssq_pkg::CAPACITY slots; equal
// keys leave in arrival order. A push (action 0) inserts a word, a pop
// (action 1) removes the front; a pop on an empty queue or a push into a full
// one answers ok=0 and changes nothing. Every request word yields one response
// word with the front entry, empty flag and fill count after the operation.
// One request is taken per clock: all slot cells compare against the pushed key
// and shift in the same cycle, and the response appears in the output register
// in the cycle after acceptance. A new request is taken while the response
// register is empty or being drained.

module stable_sorted_priority_queue (
  input  wire logic clk,
  input  wire logic rst,
  ssq_req_if.sink   req,
  ssq_rsp_if.source rsp
);

  localparam int N = ssq_pkg::CAPACITY;

  ssq_pkg::entry_t     cells [N];
  logic [N-1:0]        keeps;
  ssq_pkg::entry_t     new_entry;
  ssq_pkg::entry_t     blank;
  ssq_pkg::entry_t     head_next;
  ssq_pkg::cell_ctrl_t ctrl;

  logic [ssq_pkg::COUNT_W-1:0] count;
  logic [ssq_pkg::COUNT_W-1:0] count_next;

  logic                        out_valid;
  logic                        out_ok;
  logic                        out_empty;
  logic [ssq_pkg::KEY_W-1:0]   out_key;
  logic [ssq_pkg::KEY_W-1:0]   out_trans;
  logic [ssq_pkg::TYPE_W-1:0]  out_type;
  logic [ssq_pkg::FILL_W-1:0]  out_fill;

  logic accept;
  logic full;
  logic empty;

  assign req.ready = !out_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign full      = (count == ssq_pkg::COUNT_W'(N));
  assign empty     = (count == '0);

  assign new_entry.valid = 1'b1;
  assign new_entry.key   = req.key_time;
  assign new_entry.trans = req.transaction_time;
  assign new_entry.etype = req.event_type;
  assign blank           = '0;

  always_comb begin
    ctrl.key   = req.key_time;
    ctrl.op    = ssq_pkg::OP_HOLD;
    count_next = count;
    if (accept) begin
      if (req.action == ssq_pkg::ACTION_PUSH && !full) begin
        ctrl.op    = ssq_pkg::OP_INSERT;
        count_next = count + 1'b1;
      end else if (req.action == ssq_pkg::ACTION_POP && !empty) begin
        ctrl.op    = ssq_pkg::OP_ADVANCE;
        count_next = count - 1'b1;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    ssq_pkg::entry_t left_entry;
    ssq_pkg::entry_t right_entry;
    logic            left_keep;

    if (i == 0) begin : g_first
      assign left_entry = blank;
      assign left_keep  = 1'b1;
    end else begin : g_inner
      assign left_entry = cells[i-1];
      assign left_keep  = keeps[i-1];
    end

    if (i == N - 1) begin : g_last
      assign right_entry = blank;
    end else begin : g_body
      assign right_entry = cells[i+1];
    end

    ssq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .new_entry (new_entry),
      .left      (left_entry),
      .left_keep (left_keep),
      .right     (right_entry),
      .cur       (cells[i]),
      .keep      (keeps[i])
    );
  end

  always_comb begin
    case (ctrl.op)
      ssq_pkg::OP_INSERT: begin
        head_next = keeps[0] ? cells[0] : new_entry;
      end
      ssq_pkg::OP_ADVANCE: begin
        head_next = cells[1];
      end
      default: begin
        head_next = cells[0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_ok    <= (ctrl.op != ssq_pkg::OP_HOLD);
      out_empty <= !head_next.valid;
      out_key   <= head_next.valid ? head_next.key : '0;
      out_trans <= head_next.valid ? head_next.trans : '0;
      out_type  <= head_next.valid ? head_next.etype : '0;
      out_fill  <= ssq_pkg::FILL_W'(count_next);
    end
  end

  assign rsp.valid            = out_valid;
  assign rsp.ok               = out_ok;
  assign rsp.empty_res        = out_empty;
  assign rsp.head_key         = out_key;
  assign rsp.head_transaction = out_trans;
  assign rsp.head_type        = out_type;
  assign rsp.fill_count       = out_fill;

endmodule

`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// testbench for stable_sorted_priority_queue: directed, full-queue and random
// push/pop words, each response word checked against a sorted-list predictor
// depends on ssq_pkg, ssq_if (ssq_req_if, ssq_rsp_if) and the queue rtl

module tb_top;
  import ssq_pkg::*;

  localparam int RUN_LIMIT = 400000;
  localparam int MAX_IDLE  = 14;
  localparam logic [KEY_W-1:0] KEY_MAX = '1;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [KEY_W-1:0]  trans;
    logic [TYPE_W-1:0] etype;
  } event_t;

  typedef struct packed {
    logic              ok;
    logic              empty;
    logic [KEY_W-1:0]  key;
    logic [KEY_W-1:0]  trans;
    logic [TYPE_W-1:0] etype;
    logic [FILL_W-1:0] fill;
  } head_word_t;

  logic clk = 1'b0;
  logic rst;

  ssq_req_if req ();
  ssq_rsp_if rsp ();

  stable_sorted_priority_queue dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  event_t      queued_events[$];
  head_word_t  pending_heads[$];
  head_word_t  got_word;
  head_word_t  want_word;
  bit          idling = 1'b1;
  int unsigned ready_hold = 0;
  int unsigned mismatches = 0;
  int unsigned words_checked = 0;
  int unsigned pushes_stored = 0;
  int unsigned pushes_refused = 0;
  int unsigned pops_taken = 0;
  int unsigned pops_empty = 0;

  initial forever #2 clk = ~clk;

  initial begin
    repeat (RUN_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d words still expected", RUN_LIMIT,
             pending_heads.size());
    $display("Some tests failed");
    $finish;
  end

  // stable sorted insert: new event goes after every key <= its own
  function automatic head_word_t apply_request(logic action, event_t ev);
    head_word_t w;
    int pos;
    w = '0;
    if (action == ACTION_PUSH) begin
      if (queued_events.size() < CAPACITY) begin
        pos = 0;
        while (pos < queued_events.size() && queued_events[pos].key <= ev.key) pos++;
        queued_events.insert(pos, ev);
        w.ok = 1'b1;
      end
    end else if (queued_events.size() > 0) begin
      void'(queued_events.pop_front());
      w.ok = 1'b1;
    end
    w.empty = (queued_events.size() == 0);
    if (!w.empty) begin
      w.key   = queued_events[0].key;
      w.trans = queued_events[0].trans;
      w.etype = queued_events[0].etype;
    end
    w.fill = FILL_W'(queued_events.size());
    return w;
  endfunction

  function automatic event_t random_event();
    event_t ev;
    case ($urandom_range(0, 3))
      0: ev.key = KEY_W'($urandom_range(0, 15));
      1: ev.key = $urandom_range(0, 1) ? KEY_MAX : '0;
      2: ev.key = KEY_MAX - KEY_W'($urandom_range(0, 15));
      default: ev.key = KEY_W'($urandom);
    endcase
    ev.trans = KEY_W'($urandom);
    ev.etype = TYPE_W'($urandom);
    return ev;
  endfunction

  task automatic send_word(logic action, event_t ev);
    int unsigned gap;
    head_word_t w;
    gap = idling ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid            <= 1'b1;
    req.action           <= action;
    req.key_time         <= ev.key;
    req.transaction_time <= ev.trans;
    req.event_type       <= ev.etype;
    do @(posedge clk); while (!req.ready);
    w = apply_request(action, ev);
    pending_heads.push_back(w);
    if (action == ACTION_PUSH) begin
      if (w.ok) pushes_stored++;
      else pushes_refused++;
    end else begin
      if (w.ok) pops_taken++;
      else pops_empty++;
    end
  endtask

  task automatic wait_for_heads(int unsigned tail);
    req.valid <= 1'b0;
    do @(posedge clk); while (pending_heads.size() != 0);
    repeat (tail) @(posedge clk);
  endtask

  task automatic test_directed();
    send_word(ACTION_POP, event_t'{KEY_MAX, KEY_MAX, 8'hff});
    send_word(ACTION_PUSH, event_t'{KEY_MAX, KEY_MAX, 8'hff});
    send_word(ACTION_PUSH, event_t'{'0, '0, 8'h00});
    // equal keys must leave in arrival order
    send_word(ACTION_PUSH, event_t'{KEY_MAX, 31'h1, 8'h01});
    send_word(ACTION_PUSH, event_t'{'0, 31'h2, 8'h02});
    send_word(ACTION_PUSH, event_t'{31'h0000_1000, 31'h3, 8'h03});
    send_word(ACTION_PUSH, event_t'{31'h5555_5555, 31'h2aaa_aaaa, 8'h55});
    send_word(ACTION_PUSH, event_t'{31'h2aaa_aaaa, 31'h5555_5555, 8'haa});
    repeat (7) send_word(ACTION_POP, event_t'{'0, '0, 8'h00});
    send_word(ACTION_POP, event_t'{'0, '0, 8'h00});
    wait_for_heads(4);
  endtask

  task automatic test_full_queue();
    event_t ev;
    repeat (CAPACITY + 2) begin
      ev = random_event();
      ev.key = KEY_W'($urandom_range(0, 3));
      send_word(ACTION_PUSH, ev);
    end
    repeat (CAPACITY + 2) send_word(ACTION_POP, random_event());
    wait_for_heads(4);
  endtask

  task automatic test_random(int unsigned count, int unsigned push_pct);
    repeat (count) begin
      if ($urandom_range(1, 100) <= push_pct) send_word(ACTION_PUSH, random_event());
      else send_word(ACTION_POP, random_event());
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (rsp.valid && rsp.ready) begin
        words_checked++;
        got_word = {rsp.ok, rsp.empty_res, rsp.head_key, rsp.head_transaction,
                    rsp.head_type, rsp.fill_count};
        if (pending_heads.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected response word %p", got_word);
        end else begin
          want_word = pending_heads.pop_front();
          if (got_word.ok !== want_word.ok || got_word.empty !== want_word.empty ||
              got_word.key !== want_word.key || got_word.trans !== want_word.trans ||
              got_word.etype !== want_word.etype || got_word.fill !== want_word.fill) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("word %0d expected ok=%b empty=%b key=%h trans=%h type=%h fill=%0d",
                       words_checked, want_word.ok, want_word.empty, want_word.key,
                       want_word.trans, want_word.etype, want_word.fill);
              $display("word %0d actual   ok=%b empty=%b key=%h trans=%h type=%h fill=%0d",
                       words_checked, got_word.ok, got_word.empty, got_word.key,
                       got_word.trans, got_word.etype, got_word.fill);
            end
          end
        end
        ready_hold = idling ? $urandom_range(0, MAX_IDLE) : 0;
      end else if (ready_hold > 0) begin
        ready_hold--;
      end
    end
    rsp.ready <= (ready_hold == 0);
  end

  initial begin
    rst                  <= 1'b1;
    req.valid            <= 1'b0;
    req.action           <= ACTION_PUSH;
    req.key_time         <= '0;
    req.transaction_time <= '0;
    req.event_type       <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    idling = 1'b1;
    test_full_queue();
    idling = 1'b0;
    test_full_queue();

    idling = 1'b1;
    test_random(300, 75);
    idling = 1'b0;
    test_random(200, 50);
    idling = 1'b1;
    test_random(300, 25);
    wait_for_heads(4);
    test_random(400, 55);
    idling = 1'b0;
    test_random(200, 70);
    idling = 1'b1;
    test_random(400, 45);
    test_random(200, 30);

    wait_for_heads(4);
    $display("%0d response words checked: %0d pushes stored, %0d refused on a full queue,",
             words_checked, pushes_stored, pushes_refused);
    $display("%0d pops taken, %0d pops on an empty queue, %0d mismatches",
             pops_taken, pops_empty, mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/ssq_pkg.sv
src/ssq_if.sv
src/ssq_cell.sv
src/stable_sorted_priority_queue.sv
verif/tb_top.sv
